### design/xts_pkg.sv
// Shared types, character codes and helpers for the XML token splitter.
`timescale 1ns / 1ps

package xts_pkg;

  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_EQUALS   = 8'h3D;
  localparam logic [7:0] CH_BANG     = 8'h21;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_LT       = 8'h3C;
  localparam logic [7:0] CH_GT       = 8'h3E;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_SQUOTE   = 8'h27;

  localparam int LINE_W = 24;
  localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

  // Result queue depth; must be at least two so a two-result item fits.
  localparam int QUEUE_DEPTH = 3;

  typedef struct packed {
    logic [7:0]        out_char;
    logic              char_valid;
    logic              token_last;
    logic              eof_token;
    logic [LINE_W-1:0] line_number;
  } result_t;

  // Results caused by one item, handed from the lexer to the queue.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } lex_out_t;

  function automatic result_t make_result(logic [7:0] ch, logic valid, logic last,
                                          logic eof);
    result_t r;
    r.out_char    = ch;
    r.char_valid  = valid;
    r.token_last  = last;
    r.eof_token   = eof;
    r.line_number = '0;
    return r;
  endfunction

endpackage

### design/xts_lexer.sv
// Lexer state and per-byte classification producing up to two results.
`timescale 1ns / 1ps

module xts_lexer (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       in_char,
  input  logic             end_of_input,
  output xts_pkg::lex_out_t lex
);
  import xts_pkg::*;

  logic              text_mode, text_mode_next;
  logic              token_open, token_open_next;
  logic              in_string, in_string_next;
  logic [7:0]        quote_char, quote_char_next;
  logic [LINE_W-1:0] line_counter, line_counter_next;

  logic    is_lit;
  logic    is_quote;
  logic    is_blank;
  result_t marker;
  result_t r0, r1;
  logic [1:0] n;

  always_comb begin
    is_lit = (in_char == CH_LT) || (in_char == CH_GT) ||
             (!text_mode && ((in_char == CH_QUESTION) || (in_char == CH_EQUALS) ||
                             (in_char == CH_BANG) || (in_char == CH_SLASH)));
    is_quote = (in_char == CH_DQUOTE) || (in_char == CH_SQUOTE);
    is_blank = (in_char == CH_SPACE) || (in_char == CH_TAB);
    marker   = make_result(8'h00, 1'b0, 1'b1, 1'b0);

    text_mode_next    = text_mode;
    token_open_next   = token_open;
    in_string_next    = in_string;
    quote_char_next   = quote_char;
    line_counter_next = line_counter;
    n  = 2'd0;
    r0 = '0;
    r1 = '0;

    if (end_of_input) begin
      if (token_open || in_string) begin
        r0 = marker;
        r1 = make_result(8'h00, 1'b0, 1'b1, 1'b1);
        n  = 2'd2;
      end else begin
        r0 = make_result(8'h00, 1'b0, 1'b1, 1'b1);
        n  = 2'd1;
      end
      token_open_next = 1'b0;
      in_string_next  = 1'b0;
      quote_char_next = 8'h00;
      text_mode_next  = 1'b0;
    end else if (in_string) begin
      n = 2'd1;
      if (in_char == quote_char) begin
        r0 = make_result(in_char, 1'b1, 1'b1, 1'b0);
        in_string_next  = 1'b0;
        token_open_next = 1'b0;
        quote_char_next = 8'h00;
      end else begin
        r0 = make_result(in_char, 1'b1, 1'b0, 1'b0);
      end
    end else if (is_lit) begin
      // End any open token before the one-byte literal token.
      if (token_open) begin
        r0 = marker;
        r1 = make_result(in_char, 1'b1, 1'b1, 1'b0);
        n  = 2'd2;
      end else begin
        r0 = make_result(in_char, 1'b1, 1'b1, 1'b0);
        n  = 2'd1;
      end
      token_open_next = 1'b0;
      text_mode_next  = (in_char == CH_GT);
    end else if (!text_mode && is_quote) begin
      if (token_open) begin
        r0 = marker;
        r1 = make_result(in_char, 1'b1, 1'b0, 1'b0);
        n  = 2'd2;
      end else begin
        r0 = make_result(in_char, 1'b1, 1'b0, 1'b0);
        n  = 2'd1;
      end
      token_open_next = 1'b1;
      in_string_next  = 1'b1;
      quote_char_next = in_char;
    end else if (is_blank) begin
      if (token_open) begin
        n = 2'd1;
        if (text_mode) begin
          r0 = make_result(in_char, 1'b1, 1'b0, 1'b0);
        end else begin
          r0 = marker;
          token_open_next = 1'b0;
        end
      end
    end else begin
      if ((in_char == CH_LF) && (line_counter != LINE_MAX)) begin
        line_counter_next = line_counter + LINE_W'(1);
      end
      if ((in_char == CH_LF) || (in_char == CH_CR)) begin
        // Keep newlines inside a token, skip them otherwise.
        if (token_open) begin
          r0 = make_result(in_char, 1'b1, 1'b0, 1'b0);
          n  = 2'd1;
        end
      end else begin
        r0 = make_result(in_char, 1'b1, 1'b0, 1'b0);
        n  = 2'd1;
        token_open_next = 1'b1;
      end
    end

    r0.line_number = line_counter_next;
    r1.line_number = line_counter_next;
    lex.count = n;
    lex.res0  = r0;
    lex.res1  = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_mode    <= 1'b0;
      token_open   <= 1'b0;
      in_string    <= 1'b0;
      quote_char   <= 8'h00;
      line_counter <= '0;
    end else if (accept) begin
      text_mode    <= text_mode_next;
      token_open   <= token_open_next;
      in_string    <= in_string_next;
      quote_char   <= quote_char_next;
      line_counter <= line_counter_next;
    end
  end

endmodule

### design/xts_result_queue.sv
// Small shifting queue of results that parts the input side from the output side.
`timescale 1ns / 1ps

module xts_result_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  xts_pkg::lex_out_t lex,
  input  logic              out_stall,
  output logic              room,
  output logic              out_valid,
  output xts_pkg::result_t  head
);
  import xts_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  result_t       q [QUEUE_DEPTH];
  result_t       q_next [QUEUE_DEPTH];
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] cnt_after;
  logic [CW-1:0] cnt_plus;
  logic          pop;

  assign out_valid = (count != '0);
  assign head      = q[0];

  always_comb begin
    pop       = out_valid && !out_stall;
    cnt_after = count - CW'(pop);
    cnt_plus  = cnt_after + CW'(1);
    // Always leave space for the two results a single beat can cause.
    room      = (cnt_after <= CW'(QUEUE_DEPTH - 2));

    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_next[i] = q[i];
    end
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      if (pop) begin
        q_next[i] = q[i + 1];
      end
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (push && (lex.count != 2'd0) && (CW'(i) == cnt_after)) begin
        q_next[i] = lex.res0;
      end
      if (push && (lex.count == 2'd2) && (CW'(i) == cnt_plus)) begin
        q_next[i] = lex.res1;
      end
    end

    count_next = cnt_after + (push ? CW'(lex.count) : CW'(0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

endmodule

### design/xml_token_splitter_core.sv
// Top level of the XML token splitter: lexer feeding a result queue.
//
//   channel | direction | handshake          | beat carries
//   input   | in        | in_valid/in_stall   | in_char, end_of_input
//   output  | out       | out_valid/out_stall | out_char, char_valid, token_last,
//           |           |                     | eof_token, line_number
//
// One input beat is taken per cycle while in_stall is low; its results enter the queue
// at that same edge and can leave from the next cycle on.
// A beat that causes two results (a literal or quote closing an open token, end of
// input after an open token) needs two output beats, so the output port sets the
// sustained rate.
// Reset clears lexer state and empties the queue; in_stall is high while the queue
// cannot take two more results, and stalls on the output back up through it.
`timescale 1ns / 1ps

module xml_token_splitter_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_char,
  input  logic                        end_of_input,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_char,
  output logic                        char_valid,
  output logic                        token_last,
  output logic                        eof_token,
  output logic [xts_pkg::LINE_W-1:0]  line_number
);
  import xts_pkg::*;

  lex_out_t lex;
  result_t  head;
  logic     room;
  logic     accept;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  xts_lexer u_lexer (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_char      (in_char),
    .end_of_input (end_of_input),
    .lex          (lex)
  );

  xts_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .lex       (lex),
    .out_stall (out_stall),
    .room      (room),
    .out_valid (out_valid),
    .head      (head)
  );

  assign out_char    = head.out_char;
  assign char_valid  = head.char_valid;
  assign token_last  = head.token_last;
  assign eof_token   = head.eof_token;
  assign line_number = head.line_number;

endmodule

### design/xts_checker.sv
// Port-level checks for the XML token splitter, bound to the top level.
`timescale 1ns / 1ps

module xts_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [7:0]                 out_char,
  input logic                       char_valid,
  input logic                       token_last,
  input logic                       eof_token,
  input logic [xts_pkg::LINE_W-1:0] line_number
);
  import xts_pkg::*;

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(line_number))
    else $error("stalled output beat changed");

  // An end-of-input token is a bare end marker.
  a_eof_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && eof_token |-> token_last && !char_valid && (out_char == 8'h00))
    else $error("malformed end-of-input token");

  // A marker carries no byte.
  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !char_valid |-> token_last && (out_char == 8'h00))
    else $error("marker beat with a byte or without token_last");

  // Line count never falls between consecutive beats.
  a_line_mono: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall ##1 out_valid |-> line_number >= $past(line_number))
    else $error("line number went backwards");

  // Nothing leaves straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind xml_token_splitter_core xts_checker u_xts_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_char    (out_char),
  .char_valid  (char_valid),
  .token_last  (token_last),
  .eof_token   (eof_token),
  .line_number (line_number)
);

### dv/xml_token_splitter_core_tb.sv
// Self-checking testbench for the XML token splitter core: directed and random byte streams.
`timescale 1ns / 1ps

module xml_token_splitter_core_tb;
  import xts_pkg::*;

  localparam int RANDOM_BYTES = 1400;
  localparam int QUIET_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 16;

  typedef struct {
    logic [7:0] ch;
    logic       eoi;
    bit         hold_off;
  } feed_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_char = 8'h00;
  logic               end_of_input = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_char;
  logic               char_valid;
  logic               token_last;
  logic               eof_token;
  logic [LINE_W-1:0]  line_number;

  // Lexer state mirrored on the bench side
  bit                 lx_text_mode;
  bit                 lx_token_open;
  bit                 lx_in_string;
  logic [7:0]         lx_quote = 8'h00;
  logic [LINE_W-1:0]  lx_lines = '0;

  feed_t              byte_feed_q[$];
  result_t            token_beat_q[$];
  bit                 next_hold;
  int unsigned        cyc;
  int unsigned        quiet;
  int unsigned        errors;
  int unsigned        items_taken;
  int unsigned        beats_checked;
  int unsigned        tokens_closed;
  int unsigned        eof_seen;

  xml_token_splitter_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char      (in_char),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .char_valid   (char_valid),
    .token_last   (token_last),
    .eof_token    (eof_token),
    .line_number  (line_number)
  );

  always #1 clk = ~clk;

  // Roughly 30% idle, except in a long calm window that comes back periodically
  function automatic bit idle_now();
    if ((cyc % 2500) >= 1200 && (cyc % 2500) < 1700) return 1'b0;
    return $urandom_range(0, 99) < 30;
  endfunction

  // Work out the token beats that one input byte (or end mark) causes
  task automatic split_byte(input logic [7:0] c, input logic eoi);
    result_t r[2];
    int      n;
    bit      lit;
    n = 0;
    lit = (c == CH_LT) || (c == CH_GT) ||
          (!lx_text_mode && (c == CH_QUESTION || c == CH_EQUALS ||
                             c == CH_BANG || c == CH_SLASH));
    if (eoi) begin
      if (lx_token_open || lx_in_string) begin
        r[n] = {8'h00, 1'b0, 1'b1, 1'b0, {LINE_W{1'b0}}};
        n++;
      end
      lx_token_open = 1'b0;
      lx_in_string  = 1'b0;
      lx_quote      = 8'h00;
      lx_text_mode  = 1'b0;
      r[n] = {8'h00, 1'b0, 1'b1, 1'b1, {LINE_W{1'b0}}};
      n++;
    end else if (lx_in_string) begin
      if (c == lx_quote) begin
        r[n] = {c, 1'b1, 1'b1, 1'b0, {LINE_W{1'b0}}};
        n++;
        lx_in_string  = 1'b0;
        lx_token_open = 1'b0;
        lx_quote      = 8'h00;
      end else begin
        r[n] = {c, 1'b1, 1'b0, 1'b0, {LINE_W{1'b0}}};
        n++;
      end
    end else if (lit) begin
      if (lx_token_open) begin
        r[n] = {8'h00, 1'b0, 1'b1, 1'b0, {LINE_W{1'b0}}};
        n++;
        lx_token_open = 1'b0;
      end
      r[n] = {c, 1'b1, 1'b1, 1'b0, {LINE_W{1'b0}}};
      n++;
      lx_text_mode = (c == CH_GT);
    end else if (!lx_text_mode && (c == CH_DQUOTE || c == CH_SQUOTE)) begin
      // a quote ends any open token, then opens a string
      if (lx_token_open) begin
        r[n] = {8'h00, 1'b0, 1'b1, 1'b0, {LINE_W{1'b0}}};
        n++;
      end
      r[n] = {c, 1'b1, 1'b0, 1'b0, {LINE_W{1'b0}}};
      n++;
      lx_token_open = 1'b1;
      lx_in_string  = 1'b1;
      lx_quote      = c;
    end else if (c == CH_SPACE || c == CH_TAB) begin
      if (lx_token_open) begin
        if (lx_text_mode) begin
          r[n] = {c, 1'b1, 1'b0, 1'b0, {LINE_W{1'b0}}};
          n++;
        end else begin
          r[n] = {8'h00, 1'b0, 1'b1, 1'b0, {LINE_W{1'b0}}};
          n++;
          lx_token_open = 1'b0;
        end
      end
    end else begin
      if (c == CH_LF && lx_lines != LINE_MAX) lx_lines = lx_lines + LINE_W'(1);
      if (c == CH_LF || c == CH_CR) begin
        if (lx_token_open) begin
          r[n] = {c, 1'b1, 1'b0, 1'b0, {LINE_W{1'b0}}};
          n++;
        end
      end else begin
        r[n] = {c, 1'b1, 1'b0, 1'b0, {LINE_W{1'b0}}};
        n++;
        lx_token_open = 1'b1;
      end
    end
    for (int k = 0; k < n; k++) begin
      r[k].line_number = lx_lines;
      token_beat_q = {token_beat_q, r[k]};
    end
  endtask

  task automatic report_bad(input string what, input int unsigned got, input int unsigned want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_beat();
    result_t w;
    if (token_beat_q.size() == 0) begin
      report_bad("unexpected beat (out_char)", out_char, 0);
      return;
    end
    w = token_beat_q.pop_front();
    beats_checked++;
    if (token_last) tokens_closed++;
    if (eof_token) eof_seen++;
    if (out_char !== w.out_char) report_bad("out_char", out_char, w.out_char);
    if (char_valid !== w.char_valid) report_bad("char_valid", char_valid, w.char_valid);
    if (token_last !== w.token_last) report_bad("token_last", token_last, w.token_last);
    if (eof_token !== w.eof_token) report_bad("eof_token", eof_token, w.eof_token);
    if (line_number !== w.line_number) report_bad("line_number", line_number, w.line_number);
  endtask

  // Driver: hold a stalled beat, otherwise advance through the feed queue
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        split_byte(in_char, end_of_input);
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (byte_feed_q.size() != 0 && byte_feed_q[0].hold_off && token_beat_q.size() != 0) begin
          in_valid <= 1'b0;
        end else if (byte_feed_q.size() != 0 && !idle_now()) begin
          in_valid     <= 1'b1;
          in_char      <= byte_feed_q[0].ch;
          end_of_input <= byte_feed_q[0].eoi;
          void'(byte_feed_q.pop_front());
        end else begin
          in_valid     <= 1'b0;
          in_char      <= 8'($urandom_range(0, 255));
          end_of_input <= 1'($urandom_range(0, 1));
        end
      end
    end
  end

  // Monitor: check each accepted result beat, stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_beat();
      out_stall <= idle_now();
    end
  end

  // Watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("[%0t] watchdog: no beat moved for %0d cycles", $realtime, quiet);
        $display("tb: failure");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic feed(input logic [7:0] c, input logic eoi = 1'b0);
    feed_t f;
    f.ch       = c;
    f.eoi      = eoi;
    f.hold_off = next_hold;
    next_hold  = 1'b0;
    byte_feed_q = {byte_feed_q, f};
  endtask

  task automatic feed_str(input string s);
    for (int i = 0; i < s.len(); i++) feed(s[i]);
  endtask

  task automatic feed_eoi();
    feed(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic feed_name();
    int len;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 4) == 0) feed(8'($urandom_range(8'h30, 8'h39)));
      else feed(8'($urandom_range(8'h61, 8'h7A)));
    end
  endtask

  // Mostly printable content, now and then any byte at all
  task automatic feed_content(input int len);
    logic [7:0] pool[8];
    pool = '{CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_DQUOTE, CH_SQUOTE, CH_EQUALS, CH_SLASH};
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       feed(pool[3'($urandom_range(0, 7))]);
        1:       feed(8'($urandom_range(0, 255)));
        default: feed(8'($urandom_range(8'h41, 8'h7A)));
      endcase
    end
  endtask

  task automatic feed_blanks();
    logic [7:0] pool[4];
    int         len;
    pool = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
    len = $urandom_range(1, 5);
    for (int i = 0; i < len; i++) feed(pool[2'($urandom_range(0, 3))]);
  endtask

  task automatic feed_attr();
    logic [7:0] q;
    q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
    feed(CH_SPACE);
    feed_name();
    feed(CH_EQUALS);
    feed(q);
    for (int i = $urandom_range(0, 6); i > 0; i--) begin
      if ($urandom_range(0, 5) == 0) feed(8'($urandom_range(0, 255)));
      else feed(8'($urandom_range(8'h20, 8'h7E)));
    end
    if ($urandom_range(0, 9) != 0) feed(q);
  endtask

  task automatic feed_element();
    feed(CH_LT);
    feed_name();
    for (int i = $urandom_range(0, 3); i > 0; i--) feed_attr();
    if ($urandom_range(0, 3) == 0) begin
      feed(CH_SLASH);
      feed(CH_GT);
    end else begin
      feed(CH_GT);
      feed_content($urandom_range(0, 10));
      feed(CH_LT);
      feed(CH_SLASH);
      feed_name();
      feed(CH_GT);
    end
  endtask

  initial begin
    // directed: blanks with no token, blank ending a token, literals
    feed_str(" \t\r\n");
    feed_str("a");
    feed(8'hFF);
    feed_str(" c<");
    feed_str("?=!/");
    // quote mid-token, newline and literal inside a string
    feed_str("k\"\n<\"");
    // text mode: space kept, quote ordinary, literal closes
    feed_str(">t \"<");
    // newline kept in a token
    feed(8'h00);
    feed_str("\r\n");
    // end of input inside a string, then repeated; wait for the output to drain first
    feed_str("'z");
    next_hold = 1'b1;
    feed_eoi();
    feed_eoi();

    while (byte_feed_q.size() < RANDOM_BYTES + 30) begin
      if ($urandom_range(0, 11) == 0) next_hold = 1'b1;
      case ($urandom_range(0, 11))
        0, 1, 2, 3: feed_element();
        4: begin
          feed_str("<?");
          feed_name();
          feed_attr();
          feed_str("?>");
        end
        5: begin
          feed_str("<!--");
          feed_content($urandom_range(1, 8));
          feed_str("-->");
        end
        6: feed_blanks();
        7: for (int i = $urandom_range(1, 8); i > 0; i--) feed(8'($urandom_range(0, 255)));
        8: if ($urandom_range(0, 2) == 0) feed_eoi();
        9: begin
          feed(CH_GT);
          feed_content($urandom_range(1, 12));
        end
        default: begin
          feed_name();
          feed_blanks();
        end
      endcase
    end
    feed_eoi();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (byte_feed_q.size() != 0 || in_valid || token_beat_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (token_beat_q.size() != 0) report_bad("beats left over", token_beat_q.size(), 0);

    $display("tb: %0d input beats taken, %0d token beats checked", items_taken, beats_checked);
    $display("tb: %0d token ends and %0d end-of-input tokens seen, %0d lines counted",
             tokens_closed, eof_seen, lx_lines);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
